// File: hdl/qwts_pkg.sv
// ----------------------------------------------------------------------------
// qwts_pkg: shared constants and helpers for the queue wait-time simulator
// Field widths, configuration register indexes, parameter defaults and the
// whole-rate clamp.
// ----------------------------------------------------------------------------
package qwts_pkg;

    localparam int DEF_QUEUE_DEPTH    = 256;
    localparam int DEF_COUNT_WIDTH    = 32;
    localparam int DEF_FRAC_BITS      = 16;
    localparam int DEF_MAX_WHOLE_RATE = 15;

    localparam int WHOLE_W     = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int WAIT_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ARRIVE_WHOLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ARRIVE_FRAC  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEAVE_WHOLE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEAVE_FRAC   = 2'd3;

    function automatic logic [WHOLE_W-1:0] clamp_whole(
        input logic [WHOLE_W-1:0] w,
        input int                 max_rate
    );
        logic [WHOLE_W-1:0] r;
        r = w;
        if (int'(w) > max_rate)
        begin
            r = WHOLE_W'(max_rate);
        end
        return r;
    endfunction

endpackage

// File: hdl/queue_wait_time_simulator_core.sv
// ----------------------------------------------------------------------------
// queue_wait_time_simulator_core: FIFO queue wait-time simulator
// One transaction per tick: accumulate rates, enqueue stamped arrivals,
// dequeue departures and report each wait through a registered output.
// ----------------------------------------------------------------------------
// Sequence per tick: the whole enqueues, then the whole departures (each a
// registered stamp RAM read, then an output write that waits on out_ready),
// then an extra enqueue and departure from the fraction carries, then the
// tick count step. Ticks are taken one at a time: in_ready is high only in
// idle, so a new tick is accepted only after the last one has finished.
// Reset: asynchronous, active low; clears queue, counters, accumulators,
// flag and configuration registers. Stamp RAM contents are not cleared.
module queue_wait_time_simulator_core
    import qwts_pkg::*;
#(
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
    parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH,
    parameter int FRAC_BITS      = DEF_FRAC_BITS,
    parameter int MAX_WHOLE_RATE = DEF_MAX_WHOLE_RATE
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   start_run,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WAIT_W-1:0]      wait_time,
    output logic                   last_of_tick,
    output logic                   overflow_seen
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_PUSH    = 7'b0000010,
        ST_POP_RD  = 7'b0000100,
        ST_POP_OUT = 7'b0001000,
        ST_XPUSH   = 7'b0010000,
        ST_XPOP    = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [WHOLE_W-1:0]       arrive_whole_reg, leave_whole_reg;
    logic [FRAC_BITS-1:0]     arrive_frac_reg, leave_frac_reg;
    logic [PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [COUNT_WIDTH-1:0]   tick_reg, tick_next;
    logic [FRAC_BITS-1:0]     arrive_acc_reg, arrive_acc_next;
    logic [FRAC_BITS-1:0]     leave_acc_reg, leave_acc_next;
    logic                     drop_reg, drop_next;
    logic                     arrive_carry_reg, arrive_carry_next;
    logic                     leave_carry_reg, leave_carry_next;
    logic [WHOLE_W-1:0]       cnt_reg, cnt_next;
    logic                     last_reg, last_next;
    logic                     extra_reg, extra_next;
    logic                     out_valid_reg, out_valid_next;
    logic [WAIT_W-1:0]        wait_reg, wait_next;
    logic                     last_out_reg, last_out_next;
    logic                     ovf_out_reg, ovf_out_next;

    logic [FRAC_BITS:0]       arrive_sum, leave_sum;
    logic                     push_req, pop_req, full, push_ok;
    logic [FILL_W-1:0]        fill_after;
    logic                     whole_last, xpop_follows;
    logic [COUNT_WIDTH-1:0]   rd_stamp, wait_diff;
    logic                     out_free;

    qwts_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (push_ok),
        .wr_addr (wr_ptr_reg),
        .wr_data (tick_reg),
        .rd_en   (pop_req),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_stamp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrive_whole_reg <= '0;
            arrive_frac_reg  <= '0;
            leave_whole_reg  <= '0;
            leave_frac_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ARRIVE_WHOLE: arrive_whole_reg <=
                    clamp_whole(cfg_data[WHOLE_W-1:0], MAX_WHOLE_RATE);
                REG_ARRIVE_FRAC:  arrive_frac_reg  <= FRAC_BITS'(cfg_data);
                REG_LEAVE_WHOLE:  leave_whole_reg  <=
                    clamp_whole(cfg_data[WHOLE_W-1:0], MAX_WHOLE_RATE);
                REG_LEAVE_FRAC:   leave_frac_reg   <= FRAC_BITS'(cfg_data);
            endcase
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign full       = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign push_ok    = push_req && !full;
    assign fill_after = fill_reg - 1'b1;
    assign wait_diff  = tick_reg - rd_stamp;
    assign out_free   = !out_valid_reg || out_ready;

    assign arrive_sum = {1'b0, (start_run ? '0 : arrive_acc_reg)} + {1'b0, arrive_frac_reg};
    assign leave_sum  = {1'b0, (start_run ? '0 : leave_acc_reg)} + {1'b0, leave_frac_reg};

    assign whole_last   = (fill_after == '0) || (WHOLE_W'(cnt_reg + 1'b1) == leave_whole_reg);
    assign xpop_follows = leave_carry_reg && (arrive_carry_reg || (fill_after != '0));

    always_comb
    begin
        state_next        = state_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        fill_next         = fill_reg;
        tick_next         = tick_reg;
        arrive_acc_next   = arrive_acc_reg;
        leave_acc_next    = leave_acc_reg;
        drop_next         = drop_reg;
        arrive_carry_next = arrive_carry_reg;
        leave_carry_next  = leave_carry_reg;
        cnt_next          = cnt_reg;
        last_next         = last_reg;
        extra_next        = extra_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        wait_next         = wait_reg;
        last_out_next     = last_out_reg;
        ovf_out_next      = ovf_out_reg;
        push_req          = 1'b0;
        pop_req           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (start_run)
                    begin
                        rd_ptr_next = '0;
                        wr_ptr_next = '0;
                        fill_next   = '0;
                        tick_next   = '0;
                        drop_next   = 1'b0;
                    end
                    arrive_acc_next   = arrive_sum[FRAC_BITS-1:0];
                    leave_acc_next    = leave_sum[FRAC_BITS-1:0];
                    arrive_carry_next = arrive_sum[FRAC_BITS];
                    leave_carry_next  = leave_sum[FRAC_BITS];
                    cnt_next          = '0;
                    state_next        = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (cnt_reg == arrive_whole_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_POP_RD;
                end
                else
                begin
                    push_req = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_POP_RD:
            begin
                if ((cnt_reg == leave_whole_reg) || (fill_reg == '0))
                begin
                    state_next = ST_XPUSH;
                end
                else
                begin
                    pop_req    = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    last_next  = whole_last && !xpop_follows;
                    extra_next = 1'b0;
                    state_next = ST_POP_OUT;
                end
            end
            ST_POP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    wait_next      = WAIT_W'(wait_diff);
                    last_out_next  = last_reg;
                    ovf_out_next   = drop_reg;
                    state_next     = extra_reg ? ST_FINISH : ST_POP_RD;
                end
            end
            ST_XPUSH:
            begin
                push_req   = arrive_carry_reg;
                state_next = ST_XPOP;
            end
            ST_XPOP:
            begin
                if (leave_carry_reg && (fill_reg != '0))
                begin
                    pop_req    = 1'b1;
                    last_next  = 1'b1;
                    extra_next = 1'b1;
                    state_next = ST_POP_OUT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                tick_next  = tick_reg + 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_req)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                fill_next   = fill_reg + 1'b1;
            end
        end
        if (pop_req)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            fill_reg         <= '0;
            tick_reg         <= '0;
            arrive_acc_reg   <= '0;
            leave_acc_reg    <= '0;
            drop_reg         <= 1'b0;
            arrive_carry_reg <= 1'b0;
            leave_carry_reg  <= 1'b0;
            cnt_reg          <= '0;
            last_reg         <= 1'b0;
            extra_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            fill_reg         <= fill_next;
            tick_reg         <= tick_next;
            arrive_acc_reg   <= arrive_acc_next;
            leave_acc_reg    <= leave_acc_next;
            drop_reg         <= drop_next;
            arrive_carry_reg <= arrive_carry_next;
            leave_carry_reg  <= leave_carry_next;
            cnt_reg          <= cnt_next;
            last_reg         <= last_next;
            extra_reg        <= extra_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wait_reg     <= wait_next;
        last_out_reg <= last_out_next;
        ovf_out_reg  <= ovf_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign wait_time     = wait_reg;
    assign last_of_tick  = last_out_reg;
    assign overflow_seen = ovf_out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill level above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with unequal pointers");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop_req |-> (fill_reg != '0))
        else $error("dequeue from empty queue");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_OUT) |-> !in_ready)
        else $error("transaction accepted while a departure is pending");

endmodule

// File: hdl/qwts_ram.sv
// ----------------------------------------------------------------------------
// qwts_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module qwts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
